### src/lpcf_pkg.sv
// Shared types and constants for the length-prefixed command framer.
// Holds the phase enum, the operation codes and the packed result layout.
// No dependencies.
`default_nettype none

package lpcf_pkg;

  // Framing geometry
  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned BUFFER_BYTES = 4096;

  // Header bytes (1-based count after the byte) that carry the big-endian length
  localparam int unsigned LEN_FIRST = 3;
  localparam int unsigned LEN_LAST  = 6;

  // Field widths
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 32;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CNT_W-1:0] MAX_LEN_RESET = CNT_W'(4096);
  // Register select is paddr[2]: word 0 is max_command_len
  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_READY  = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_CONSUME = 1'b1
  } op_t;

  // Result transaction, last field in the lowest bits, padded to 72 bits
  typedef struct packed {
    logic [2:0]        pad;
    logic              frame_done;
    logic [LEN_W-1:0]  command_length;
    logic [CNT_W-1:0]  bytes_received;
    phase_t            frame_status;
    logic [DATA_W-1:0] buf_data;
    logic [ADDR_W-1:0] buf_addr;
    logic              buf_write;
  } result_t;

endpackage

`default_nettype wire

### src/length_prefixed_command_framer.sv
// Top level of the length-prefixed command framer.
// Depends on lpcf_pkg and lpcf_cfg.
//
// Usage:
//   Input stream (in_*): one transaction per received byte or consume request.
//   in_tuser selects the operation (0 = byte, 1 = consume), in_tdata carries
//   the byte. Each byte is stored at the running count; the total length is
//   read big-endian from header bytes 2 to 5 once the 10-byte header is in.
//   Output stream (out_*): exactly one result transaction per input
//   transaction, giving the buffer write and the frame status after the item.
//   Throughput is one transaction per cycle while in_tready is high; the
//   framing state is updated in the acceptance cycle by a single
//   counter/compare pass, so the next item may follow at once.
//   A two-entry output (result register plus skid register) lets one more
//   transaction in while the receiver stalls; in_tready drops only when both
//   are full.
//   Reset (rst_n low, synchronous) empties the output, returns to the header
//   phase with count and length at zero, and sets max_command_len to 4096.
//   Write the configuration register only while the block is idle.
`default_nettype none

module length_prefixed_command_framer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,  // [7:0] rx_byte
  input  wire logic                                in_tuser,  // [0] operation
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] buf_write, [12:1] buf_addr, [20:13] buf_data, [22:21] frame_status,
  // [35:23] bytes_received, [67:36] command_length, [68] frame_done, [71:69] 0
  output logic      [71:0]                         out_tdata,
  // Configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [lpcf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [lpcf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [lpcf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int unsigned CNT_W = lpcf_pkg::CNT_W;
  localparam int unsigned LEN_W = lpcf_pkg::LEN_W;

  // Framing state
  lpcf_pkg::phase_t   phase_r, phase_nxt;
  logic [CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [LEN_W-1:0]   total_length_r, total_length_nxt;
  logic [LEN_W-1:0]   len_acc_r, len_acc_nxt;

  // Output buffering
  lpcf_pkg::result_t  out_r, skid_r, res;
  logic               out_vld_r, skid_vld_r;

  logic [CNT_W-1:0]   max_len;
  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   cnt_inc;
  logic               in_acc;
  logic               consume;
  logic               collecting;
  logic               full;
  logic               store;
  logic               hdr_store;
  logic               hdr_done;
  logic               len_bad;

  lpcf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  // ---------------------------------------------------------------------
  // Handshake: hold off only when the skid register is occupied
  // ---------------------------------------------------------------------
  assign in_tready  = !skid_vld_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // ---------------------------------------------------------------------
  // Datapath: count, length shift register and buffer write
  // ---------------------------------------------------------------------
  // Effective capacity: smaller of the register and the buffer size
  assign cap = (max_len > CNT_W'(lpcf_pkg::BUFFER_BYTES)) ?
               CNT_W'(lpcf_pkg::BUFFER_BYTES) : max_len;

  assign consume    = in_acc && (in_tuser == lpcf_pkg::OP_CONSUME);
  assign collecting = (phase_r == lpcf_pkg::PH_HEADER) || (phase_r == lpcf_pkg::PH_BODY);
  assign full       = byte_count_r >= cap;
  assign cnt_inc    = byte_count_r + CNT_W'(1);
  assign store      = in_acc && (in_tuser == lpcf_pkg::OP_BYTE) && collecting && !full;
  assign hdr_store  = store && (phase_r == lpcf_pkg::PH_HEADER);
  assign hdr_done   = hdr_store && (cnt_inc == CNT_W'(lpcf_pkg::HEADER_BYTES));

  always_comb begin
    byte_count_nxt   = byte_count_r;
    len_acc_nxt      = len_acc_r;
    total_length_nxt = total_length_r;
    if (consume) begin
      byte_count_nxt   = '0;
      len_acc_nxt      = '0;
      total_length_nxt = '0;
    end else if (store) begin
      byte_count_nxt = cnt_inc;
      // Shift in the big-endian length bytes
      if (hdr_store && (cnt_inc >= CNT_W'(lpcf_pkg::LEN_FIRST)) &&
          (cnt_inc <= CNT_W'(lpcf_pkg::LEN_LAST))) begin
        len_acc_nxt = {len_acc_r[LEN_W-9:0], in_tdata};
      end
      if (hdr_done) begin
        total_length_nxt = len_acc_nxt;
      end
    end
  end

  assign len_bad = (len_acc_nxt < LEN_W'(lpcf_pkg::HEADER_BYTES)) ||
                   (len_acc_nxt > LEN_W'(max_len)) ||
                   (len_acc_nxt > LEN_W'(lpcf_pkg::BUFFER_BYTES));

  // ---------------------------------------------------------------------
  // Phase: next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    if (consume) begin
      phase_nxt = lpcf_pkg::PH_HEADER;
    end else if (in_acc) begin
      unique case (phase_r)
        lpcf_pkg::PH_HEADER: begin
          if (full) begin
            phase_nxt = lpcf_pkg::PH_ERROR;
          end else if (hdr_done) begin
            priority if (len_bad) begin
              phase_nxt = lpcf_pkg::PH_ERROR;
            end else if (len_acc_nxt == LEN_W'(lpcf_pkg::HEADER_BYTES)) begin
              phase_nxt = lpcf_pkg::PH_READY;
            end else begin
              phase_nxt = lpcf_pkg::PH_BODY;
            end
          end
        end
        lpcf_pkg::PH_BODY: begin
          if (full) begin
            phase_nxt = lpcf_pkg::PH_ERROR;
          end else if (LEN_W'(cnt_inc) == total_length_r) begin
            phase_nxt = lpcf_pkg::PH_READY;
          end
        end
        // Ready or error: drop bytes, hold until consumed
        lpcf_pkg::PH_READY, lpcf_pkg::PH_ERROR: phase_nxt = phase_r;
        default: phase_nxt = lpcf_pkg::PH_ERROR;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result for the accepted transaction
  // ---------------------------------------------------------------------
  always_comb begin
    res                = '0;
    res.buf_write      = store;
    res.buf_addr       = store ? byte_count_r[lpcf_pkg::ADDR_W-1:0] : '0;
    res.buf_data       = store ? in_tdata : '0;
    res.frame_status   = phase_nxt;
    res.bytes_received = byte_count_nxt;
    res.command_length = total_length_nxt;
    res.frame_done     = (phase_nxt == lpcf_pkg::PH_READY) ||
                         (phase_nxt == lpcf_pkg::PH_ERROR);
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lpcf_pkg::PH_HEADER;
      byte_count_r   <= '0;
      total_length_r <= '0;
      len_acc_r      <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      total_length_r <= total_length_nxt;
      len_acc_r      <= len_acc_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid: advance the skid entry when the output drains
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_tready) begin
          skid_vld_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_vld_r || out_tready) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_tready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty output register");

  a_done_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.frame_done == out_r.frame_status[1]))
    else $error("frame_done disagrees with frame_status");

  a_no_write_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.buf_write) |-> (out_r.buf_addr == '0 && out_r.buf_data == '0))
    else $error("address or data set without a buffer write");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_W'(lpcf_pkg::BUFFER_BYTES))
    else $error("byte count beyond buffer size");

  a_ready_drops_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == lpcf_pkg::OP_BYTE && phase_r == lpcf_pkg::PH_READY)
    |=> (phase_r == lpcf_pkg::PH_READY && $stable(byte_count_r)))
    else $error("byte taken while a frame is ready");

endmodule

`default_nettype wire

### src/lpcf_cfg.sv
// APB-style configuration register block for the command framer.
// Holds max_command_len; depends on lpcf_pkg.
`default_nettype none

module lpcf_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [lpcf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [lpcf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [lpcf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                    cfg_pready,
  output logic      [lpcf_pkg::CNT_W-1:0]         max_len
);

  logic [lpcf_pkg::CNT_W-1:0] max_len_r;
  logic                       wr_max_len;

  assign cfg_pready = 1'b1;
  assign wr_max_len = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == lpcf_pkg::REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpcf_pkg::MAX_LEN_RESET;
    end else if (wr_max_len) begin
      max_len_r <= cfg_pwdata[lpcf_pkg::CNT_W-1:0];
    end
  end

  // Unused word reads as zero
  assign cfg_prdata = (cfg_paddr[2] == lpcf_pkg::REG_MAX_LEN) ?
                      lpcf_pkg::CFG_DATA_W'(max_len_r) : '0;
  assign max_len    = max_len_r;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_command_framer.
// Depends on lpcf_pkg and the framer RTL; drives byte and consume transactions,
// predicts every result in a local framing model and checks it field by field.

module tb;
  import lpcf_pkg::*;

  localparam int unsigned TIMEOUT_NS = 6_000_000;

  // One row of the opening table: the transaction plus, where obvious, its result
  typedef struct {
    op_t        op;
    logic [7:0] rx;
    bit         typed;
    result_t    res;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] rx_byte
  logic                  in_tuser;   // [0] operation
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] buf_write, [12:1] buf_addr, [20:13] buf_data, [22:21] frame_status,
  // [35:23] bytes_received, [67:36] command_length, [68] frame_done, [71:69] 0
  logic [71:0]           out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  length_prefixed_command_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Framing state as the block should hold it
  phase_t      fr_phase;
  logic [12:0] fr_count;
  logic [31:0] fr_len;
  logic [31:0] fr_len_acc;
  logic [12:0] max_len_reg;

  result_t     expected_results[$];
  int unsigned mismatches;
  int unsigned useful_items;   // stored bytes and consumes, dropped bytes excluded
  int          burst_left;
  bit          sender_steady;

  logic [31:0] ready_pat;
  int          pat_pos;

  function automatic result_t mk_res(logic wr, logic [11:0] addr, logic [7:0] d,
                                     phase_t st, logic [12:0] cnt, logic [31:0] len);
    result_t r;
    r                = '0;
    r.buf_write      = wr;
    r.buf_addr       = addr;
    r.buf_data       = d;
    r.frame_status   = st;
    r.bytes_received = cnt;
    r.command_length = len;
    r.frame_done     = (st == PH_READY || st == PH_ERROR);
    return r;
  endfunction

  // Advance the framing state by one transaction and return the result it gives
  function automatic result_t frame_step(op_t op, logic [7:0] b);
    int unsigned cap;
    logic        wr;
    logic [11:0] addr;
    logic [7:0]  data;
    wr   = 1'b0;
    addr = '0;
    data = '0;
    if (op == OP_CONSUME) begin
      fr_phase   = PH_HEADER;
      fr_count   = '0;
      fr_len     = '0;
      fr_len_acc = '0;
    end else if (fr_phase == PH_HEADER || fr_phase == PH_BODY) begin
      cap = (max_len_reg > BUFFER_BYTES) ? BUFFER_BYTES : max_len_reg;
      if (fr_count >= cap) begin
        // buffer full, in the header or the body: refuse the byte
        fr_phase = PH_ERROR;
      end else begin
        wr       = 1'b1;
        addr     = fr_count[11:0];
        data     = b;
        fr_count = fr_count + 13'd1;
        if (fr_phase == PH_HEADER) begin
          if (fr_count >= LEN_FIRST && fr_count <= LEN_LAST) begin
            fr_len_acc = {fr_len_acc[23:0], b};
          end
          if (fr_count == HEADER_BYTES) begin
            fr_len = fr_len_acc;
            if (fr_len < HEADER_BYTES || fr_len > max_len_reg || fr_len > BUFFER_BYTES) begin
              fr_phase = PH_ERROR;
            end else if (fr_len == HEADER_BYTES) begin
              fr_phase = PH_READY;
            end else begin
              fr_phase = PH_BODY;
            end
          end
        end else if (fr_count == fr_len) begin
          fr_phase = PH_READY;
        end
      end
    end
    return mk_res(wr, addr, data, fr_phase, fr_count, fr_len);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Present one transaction, hold it until accepted, then log its expected result.
  // The sender works in bursts; a gap lowers tvalid only when it is non-empty.
  task automatic send_item(input op_t op, input logic [7:0] rx, input bit typed,
                           input result_t typed_res);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    predicted = frame_step(op, rx);
    expected_results.push_back(typed ? typed_res : predicted);
    if (predicted.buf_write || op == OP_CONSUME) useful_items++;
    burst_left--;
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write max_command_len with an idle block: setup cycle, then access cycle
  task automatic write_max_command_len(input logic [12:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({REG_MAX_LEN, 2'b00});
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    max_len_reg = value;
  endtask

  // Send a frame whose header carries len; stop after total bytes, add extra bytes
  // (dropped once the frame is ready or in error), then consume
  task automatic send_frame(input logic [31:0] len, input int total, input int extra);
    int         i;
    logic [7:0] b;
    for (i = 0; i < total; i++) begin
      if (i + 1 >= LEN_FIRST && i + 1 <= LEN_LAST) begin
        b = len[8 * (LEN_LAST - 1 - i) +: 8];
      end else begin
        b = 8'($urandom);
      end
      send_item(OP_BYTE, b, 1'b0, '0);
    end
    repeat (extra) send_item(OP_BYTE, 8'($urandom), 1'b0, '0);
    send_item(OP_CONSUME, 8'($urandom), 1'b0, '0);
  endtask

  // Mostly well-formed frames with random content; some bad lengths, some cut
  // short, some plain noise
  task automatic random_frame();
    int unsigned cap;
    int unsigned hi;
    int          kind;
    int          total;
    logic [31:0] len;
    bit          fits;
    sender_steady = ($urandom_range(0, 3) == 0);
    cap  = (max_len_reg > BUFFER_BYTES) ? BUFFER_BYTES : max_len_reg;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 20)) begin
        send_item(op_t'($urandom_range(0, 7) == 0), 8'($urandom), 1'b0, '0);
      end
      send_item(OP_CONSUME, 8'($urandom), 1'b0, '0);
      return;
    end
    if (kind < 60) begin
      hi  = (cap < HEADER_BYTES) ? HEADER_BYTES + 30 :
            (cap > HEADER_BYTES + 40) ? HEADER_BYTES + 40 : cap;
      len = $urandom_range(HEADER_BYTES, hi);
    end else if (kind < 68) begin
      len = HEADER_BYTES;
    end else if (kind < 76) begin
      len = $urandom_range(0, HEADER_BYTES - 1);
    end else if (kind < 86) begin
      len = max_len_reg + $urandom_range(1, 300);
    end else begin
      len = $urandom;
    end
    fits  = (len >= HEADER_BYTES && len <= max_len_reg && len <= BUFFER_BYTES);
    total = fits ? int'(len) : int'(HEADER_BYTES);
    if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
    send_frame(len, total, $urandom_range(0, 2));
    // now and then let everything come back before going on
    if ($urandom_range(0, 19) == 0) drain_results();
  endtask

  // Receiver: stall on a 32-bit pattern, reshuffled each round; some rounds
  // never stall
  always @(posedge clk) begin
    if (pat_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = '1;
        1:       ready_pat = $urandom;
        2:       ready_pat = $urandom & $urandom;
        default: ready_pat = $urandom | $urandom;
      endcase
      ready_pat[0] = 1'b1;
    end
    out_tready <= ready_pat[pat_pos];
    pat_pos = (pat_pos + 1) % 32;
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with nothing expected", out_tdata));
      end else begin
        want = expected_results.pop_front();
        compare_field("buf_write",      32'(got.buf_write),      32'(want.buf_write));
        compare_field("buf_addr",       32'(got.buf_addr),       32'(want.buf_addr));
        compare_field("buf_data",       32'(got.buf_data),       32'(want.buf_data));
        compare_field("frame_status",   32'(got.frame_status),   32'(want.frame_status));
        compare_field("bytes_received", 32'(got.bytes_received), 32'(want.bytes_received));
        compare_field("command_length", got.command_length,      want.command_length);
        compare_field("frame_done",     32'(got.frame_done),     32'(want.frame_done));
        compare_field("padding",        32'(got.pad),            32'(want.pad));
      end
    end
  end

  initial begin
    opening_row_t opening_rows[24];
    logic [12:0]  max_settings[6];
    int           i;
    int unsigned  target;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    ready_pat   = '1;
    pat_pos     = 0;
    mismatches  = 0;
    useful_items = 0;
    burst_left  = 0;
    sender_steady = 1'b0;
    fr_phase    = PH_HEADER;
    fr_count    = '0;
    fr_len      = '0;
    fr_len_acc  = '0;
    max_len_reg = MAX_LEN_RESET;

    // Opening table: consume from reset, a header-only frame (length equal to
    // the header), a byte dropped while ready, and a length above the maximum
    opening_rows = '{
      '{OP_CONSUME, 8'h00, 1'b1, mk_res(1'b0, 12'd0, 8'h00, PH_HEADER, 13'd0, 32'd0)},
      '{OP_BYTE,    8'hFF, 1'b1, mk_res(1'b1, 12'd0, 8'hFF, PH_HEADER, 13'd1, 32'd0)},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h0A, 1'b0, '0},
      '{OP_BYTE,    8'h80, 1'b0, '0},
      '{OP_BYTE,    8'h7F, 1'b0, '0},
      '{OP_BYTE,    8'h55, 1'b0, '0},
      '{OP_BYTE,    8'hAA, 1'b1, mk_res(1'b1, 12'd9, 8'hAA, PH_READY, 13'd10, 32'd10)},
      '{OP_BYTE,    8'h3C, 1'b1, mk_res(1'b0, 12'd0, 8'h00, PH_READY, 13'd10, 32'd10)},
      '{OP_CONSUME, 8'hC3, 1'b1, mk_res(1'b0, 12'd0, 8'h00, PH_HEADER, 13'd0, 32'd0)},
      '{OP_BYTE,    8'h01, 1'b0, '0},
      '{OP_BYTE,    8'h02, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'h10, 1'b0, '0},
      '{OP_BYTE,    8'h01, 1'b0, '0},
      '{OP_BYTE,    8'hFE, 1'b0, '0},
      '{OP_BYTE,    8'hEF, 1'b0, '0},
      '{OP_BYTE,    8'h00, 1'b0, '0},
      '{OP_BYTE,    8'hFF, 1'b1, mk_res(1'b1, 12'd9, 8'hFF, PH_ERROR, 13'd10, 32'h1001)},
      '{OP_CONSUME, 8'hFF, 1'b1, mk_res(1'b0, 12'd0, 8'h00, PH_HEADER, 13'd0, 32'd0)}
    };

    // Hold reset at the start, once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_steady = 1'b1;
    for (i = 0; i < 24; i++) begin
      send_item(opening_rows[i].op, opening_rows[i].rx, opening_rows[i].typed,
                opening_rows[i].res);
    end

    // Random part across several maximum lengths: reset value, the smallest legal
    // one, one below the header (buffer fills before the header completes), one
    // past the buffer, a random middle value, and the reset value again
    max_settings = '{13'd4096, 13'd10, 13'd8, 13'd8191, 13'd0, 13'd4096};
    for (i = 0; i < 6; i++) begin
      if (i == 4) max_settings[i] = 13'($urandom_range(11, 300));
      write_max_command_len(max_settings[i]);
      target = useful_items + 64;
      while (useful_items < target) random_frame();
    end

    // One frame of exactly the configured maximum, ending at its last address
    write_max_command_len(13'd60);
    sender_steady = ($urandom_range(0, 1) == 0);
    send_frame(32'(max_len_reg), int'(max_len_reg), 1);

    drain_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
src/lpcf_pkg.sv
src/lpcf_cfg.sv
src/length_prefixed_command_framer.sv
tb/tb.sv
